[rtl/sdg_pkg.sv]
`default_nettype none

package sdg_pkg;

    localparam int STROKE_DIVISOR = 8;
    localparam int MAX_WIDTH      = 64;
    localparam int CFG_BITS       = 7;
    localparam int DIGIT_BITS     = 4;
    localparam int ROW_BITS       = 7;
    localparam int TH_BITS        = ROW_BITS + 1;
    localparam int RESET_WIDTH    = 16;
    localparam int LAST_DIGIT     = 9;

    typedef logic [MAX_WIDTH-1:0] t_pix;

    typedef enum logic [1:0] {
        SIDE_BAR = 2'd0,
        SIDE_L   = 2'd1,
        SIDE_R   = 2'd2,
        SIDE_B   = 2'd3
    } t_side;

    typedef struct packed {
        logic               stroke_zero;
        logic [TH_BITS-1:0] height;
        logic [TH_BITS-1:0] top_end;
        logic [TH_BITS-1:0] bot_start;
        logic [TH_BITS-1:0] up4_end;
        logic [TH_BITS-1:0] bar4_end;
        logic [TH_BITS-1:0] upg_end;
        logic [TH_BITS-1:0] mid_end;
        t_pix               left_clear;
        t_pix               right_clear;
    } t_geom;

    function automatic t_pix low_ones(input logic [CFG_BITS-1:0] n);
        t_pix one;
        one = t_pix'(1);
        if (n >= CFG_BITS'(MAX_WIDTH)) begin
            return '1;
        end
        return (one << n) - one;
    endfunction

    function automatic t_geom geom_of(input logic [CFG_BITS-1:0] val);
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] s_narrow;
        logic [TH_BITS-1:0]  s;
        logic [TH_BITS-1:0]  h;
        logic [TH_BITS-1:0]  up4;
        logic [TH_BITS-1:0]  rest;
        logic [TH_BITS-1:0]  upg;
        t_geom               g;
        w        = (val > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH) : val;
        s_narrow = w / CFG_BITS'(STROKE_DIVISOR);
        s        = TH_BITS'(s_narrow);
        h        = TH_BITS'(w) << 1;
        up4      = (h - s + TH_BITS'(1)) >> 1;
        rest     = h - (s + (s << 1));
        upg      = (rest + TH_BITS'(1)) >> 1;
        g.stroke_zero = (s_narrow == '0);
        g.height      = h;
        g.top_end     = s;
        g.bot_start   = h - s;
        g.up4_end     = up4;
        g.bar4_end    = up4 + s;
        g.upg_end     = s + upg;
        g.mid_end     = (s << 1) + upg;
        g.left_clear  = low_ones(w) & ~low_ones(s_narrow);
        g.right_clear = low_ones(w - s_narrow);
        return g;
    endfunction

endpackage

`default_nettype wire

[rtl/sdg_cfg.sv]
`default_nettype none

module sdg_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sdg_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    output sdg_pkg::t_geom                     o_geom
);

    // The glyph geometry is worked out once, when the width is written or on reset.
    sdg_pkg::t_geom r_geom;
    sdg_pkg::t_geom n_geom;

    always_comb begin
        n_geom = i_cfg_we ? sdg_pkg::geom_of(i_cfg_wdata) : r_geom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= sdg_pkg::geom_of(sdg_pkg::CFG_BITS'(sdg_pkg::RESET_WIDTH));
        end else begin
            r_geom <= n_geom;
        end
    end

    assign o_geom = r_geom;

endmodule

`default_nettype wire

[rtl/sdg_row.sv]
`default_nettype none

module sdg_row (
    input  wire sdg_pkg::t_geom                  i_geom,
    input  wire logic [sdg_pkg::DIGIT_BITS-1:0]  i_digit,
    input  wire logic [sdg_pkg::ROW_BITS-1:0]    i_row,
    output sdg_pkg::t_pix                        o_pixels,
    output logic                                 o_error
);

    logic [sdg_pkg::TH_BITS-1:0] row;
    sdg_pkg::t_side              kind;
    sdg_pkg::t_side              upper;
    sdg_pkg::t_side              lower;

    assign row = sdg_pkg::TH_BITS'(i_row);

    assign o_error = i_geom.stroke_zero
                  || (i_digit > sdg_pkg::DIGIT_BITS'(sdg_pkg::LAST_DIGIT))
                  || (row >= i_geom.height);

    always_comb begin
        case (i_digit)
            4'd2: begin
                upper = sdg_pkg::SIDE_R;
                lower = sdg_pkg::SIDE_L;
            end
            4'd3: begin
                upper = sdg_pkg::SIDE_R;
                lower = sdg_pkg::SIDE_R;
            end
            4'd5: begin
                upper = sdg_pkg::SIDE_L;
                lower = sdg_pkg::SIDE_R;
            end
            4'd6: begin
                upper = sdg_pkg::SIDE_L;
                lower = sdg_pkg::SIDE_B;
            end
            4'd8: begin
                upper = sdg_pkg::SIDE_B;
                lower = sdg_pkg::SIDE_B;
            end
            default: begin
                upper = sdg_pkg::SIDE_B;
                lower = sdg_pkg::SIDE_R;
            end
        endcase
    end

    always_comb begin
        case (i_digit)
            4'd0: begin
                kind = (row < i_geom.top_end || row >= i_geom.bot_start)
                     ? sdg_pkg::SIDE_BAR : sdg_pkg::SIDE_B;
            end
            4'd1: begin
                kind = sdg_pkg::SIDE_R;
            end
            4'd7: begin
                kind = (row < i_geom.top_end) ? sdg_pkg::SIDE_BAR : sdg_pkg::SIDE_R;
            end
            4'd4: begin
                if (row < i_geom.up4_end) begin
                    kind = sdg_pkg::SIDE_B;
                end else if (row < i_geom.bar4_end) begin
                    kind = sdg_pkg::SIDE_BAR;
                end else begin
                    kind = sdg_pkg::SIDE_R;
                end
            end
            default: begin
                if (row < i_geom.top_end) begin
                    kind = sdg_pkg::SIDE_BAR;
                end else if (row < i_geom.upg_end) begin
                    kind = upper;
                end else if (row < i_geom.mid_end) begin
                    kind = sdg_pkg::SIDE_BAR;
                end else if (row < i_geom.bot_start) begin
                    kind = lower;
                end else begin
                    kind = sdg_pkg::SIDE_BAR;
                end
            end
        endcase
    end

    always_comb begin
        if (o_error) begin
            o_pixels = '0;
        end else begin
            case (kind)
                sdg_pkg::SIDE_L: o_pixels = i_geom.left_clear;
                sdg_pkg::SIDE_R: o_pixels = i_geom.right_clear;
                sdg_pkg::SIDE_B: o_pixels = i_geom.left_clear & i_geom.right_clear;
                default:         o_pixels = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/scalable_digit_glyph_rows_top.sv]
`default_nettype none

// Channel  Direction  Handshake         Payload
// input    in         i_valid/o_stall   i_digit, i_row_index
// result   out        o_valid/i_stall   o_row_pixels, o_error_flag
// config   in         i_cfg_we          i_cfg_wdata (glyph width)
//
// Each item passes an input register and then a result register before its
// result is offered, and one item can enter every cycle while the result side
// is not stalled. Reset is synchronous and active low; it empties both
// registers and sets the glyph width to 16. A stalled result holds in the
// result register while one more item waits in the input register.

module scalable_digit_glyph_rows_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sdg_pkg::CFG_BITS-1:0]   i_cfg_wdata,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [sdg_pkg::DIGIT_BITS-1:0] i_digit,
    input  wire logic [sdg_pkg::ROW_BITS-1:0]   i_row_index,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [sdg_pkg::MAX_WIDTH-1:0]       o_row_pixels,
    output logic                                o_error_flag
);

    sdg_pkg::t_geom                  geom;
    sdg_pkg::t_pix                   row_pixels;
    logic                            row_error;
    logic                            out_adv;
    logic                            in_adv;

    logic                            r_in_valid;
    logic [sdg_pkg::DIGIT_BITS-1:0]  r_digit;
    logic [sdg_pkg::ROW_BITS-1:0]    r_row;
    logic                            r_out_valid;
    sdg_pkg::t_pix                   r_pixels;
    logic                            r_err;

    sdg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (geom)
    );

    sdg_row u_row (
        .i_geom   (geom),
        .i_digit  (r_digit),
        .i_row    (r_row),
        .o_pixels (row_pixels),
        .o_error  (row_error)
    );

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_digit <= i_digit;
            r_row   <= i_row_index;
        end
        if (out_adv && r_in_valid) begin
            r_pixels <= row_pixels;
            r_err    <= row_error;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_pixels = r_pixels;
    assign o_error_flag = r_err;

endmodule

`default_nettype wire

[test/scalable_digit_glyph_rows_top_test.sv]
`default_nettype none

module scalable_digit_glyph_rows_top_test;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 48;

    typedef struct packed {
        logic [sdg_pkg::DIGIT_BITS-1:0] digit;
        logic [sdg_pkg::ROW_BITS-1:0]   row;
    } t_glyph_req;

    typedef struct packed {
        sdg_pkg::t_pix pixels;
        logic          err;
    } t_row_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [sdg_pkg::CFG_BITS-1:0]   i_cfg_wdata = '0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [sdg_pkg::DIGIT_BITS-1:0] i_digit = '0;
    logic [sdg_pkg::ROW_BITS-1:0]   i_row_index = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    sdg_pkg::t_pix                  o_row_pixels;
    logic                           o_error_flag;

    t_glyph_req                   pending_items[$];
    t_row_result                  expected_rows[$];
    logic [sdg_pkg::CFG_BITS-1:0] width_reg = sdg_pkg::CFG_BITS'(sdg_pkg::RESET_WIDTH);
    logic                         in_fire = 1'b0;
    int                           queued_count = 0;
    int                           accepted_count = 0;
    int                           mismatch_count = 0;
    int                           quiet_cycles = 0;
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;
    logic                         long_hold_req = 1'b0;
    logic                         long_hold_done = 1'b0;
    int                           hold_left = 0;

    scalable_digit_glyph_rows_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_digit      (i_digit),
        .i_row_index  (i_row_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_pixels (o_row_pixels),
        .o_error_flag (o_error_flag)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic sdg_pkg::t_pix ones_below(input int n);
        if (n >= sdg_pkg::MAX_WIDTH) begin
            return '1;
        end
        return (sdg_pkg::t_pix'(1) << n) - sdg_pkg::t_pix'(1);
    endfunction

    function automatic t_row_result glyph_row_of(
        input logic [sdg_pkg::CFG_BITS-1:0]   wreg,
        input logic [sdg_pkg::DIGIT_BITS-1:0] dg,
        input logic [sdg_pkg::ROW_BITS-1:0]   row
    );
        int             w;
        int             s;
        int             h;
        int             r;
        int             up;
        sdg_pkg::t_side kind;
        sdg_pkg::t_side upper;
        sdg_pkg::t_side lower;
        sdg_pkg::t_pix  lclr;
        sdg_pkg::t_pix  rclr;
        t_row_result    res;
        w = (int'(wreg) > sdg_pkg::MAX_WIDTH) ? sdg_pkg::MAX_WIDTH : int'(wreg);
        s = w / sdg_pkg::STROKE_DIVISOR;
        h = 2 * w;
        r = int'(row);
        res.pixels = '0;
        res.err = 1'b1;
        if (s == 0 || int'(dg) > sdg_pkg::LAST_DIGIT || r >= h) begin
            return res;
        end
        kind = sdg_pkg::SIDE_BAR;
        upper = sdg_pkg::SIDE_B;
        lower = sdg_pkg::SIDE_R;
        case (dg)
            4'd0: begin
                kind = (r < s || r >= h - s) ? sdg_pkg::SIDE_BAR : sdg_pkg::SIDE_B;
            end
            4'd1: begin
                kind = sdg_pkg::SIDE_R;
            end
            4'd7: begin
                kind = (r < s) ? sdg_pkg::SIDE_BAR : sdg_pkg::SIDE_R;
            end
            4'd4: begin
                up = (h - s + 1) / 2;
                if (r < up) begin
                    kind = sdg_pkg::SIDE_B;
                end else if (r < up + s) begin
                    kind = sdg_pkg::SIDE_BAR;
                end else begin
                    kind = sdg_pkg::SIDE_R;
                end
            end
            default: begin
                case (dg)
                    4'd2: begin
                        upper = sdg_pkg::SIDE_R;
                        lower = sdg_pkg::SIDE_L;
                    end
                    4'd3: begin
                        upper = sdg_pkg::SIDE_R;
                        lower = sdg_pkg::SIDE_R;
                    end
                    4'd5: begin
                        upper = sdg_pkg::SIDE_L;
                        lower = sdg_pkg::SIDE_R;
                    end
                    4'd6: begin
                        upper = sdg_pkg::SIDE_L;
                        lower = sdg_pkg::SIDE_B;
                    end
                    4'd8: begin
                        upper = sdg_pkg::SIDE_B;
                        lower = sdg_pkg::SIDE_B;
                    end
                    default: begin
                        upper = sdg_pkg::SIDE_B;
                        lower = sdg_pkg::SIDE_R;
                    end
                endcase
                // The upper band takes the extra row when the leftover count is odd.
                up = (h - 3 * s + 1) / 2;
                if (r < s) begin
                    kind = sdg_pkg::SIDE_BAR;
                end else if (r < s + up) begin
                    kind = upper;
                end else if (r < 2 * s + up) begin
                    kind = sdg_pkg::SIDE_BAR;
                end else if (r < h - s) begin
                    kind = lower;
                end else begin
                    kind = sdg_pkg::SIDE_BAR;
                end
            end
        endcase
        lclr = ones_below(w) & ~ones_below(s);
        rclr = ones_below(w - s);
        case (kind)
            sdg_pkg::SIDE_L: res.pixels = lclr;
            sdg_pkg::SIDE_R: res.pixels = rclr;
            sdg_pkg::SIDE_B: res.pixels = lclr & rclr;
            default:         res.pixels = '0;
        endcase
        res.err = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input sdg_pkg::t_pix got,
                                   input sdg_pkg::t_pix want);
        $display("check failed at %0t: %s, got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_req(input int dg, input int row);
        t_glyph_req req;
        req.digit = sdg_pkg::DIGIT_BITS'(dg);
        req.row = sdg_pkg::ROW_BITS'(row);
        pending_items.push_back(req);
        queued_count++;
    endtask

    task automatic wait_drained;
        while (accepted_count != queued_count || expected_rows.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int width, input int count);
        int w_eff;
        int h;
        i_cfg_wdata <= sdg_pkg::CFG_BITS'(width);
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        w_eff = (width > sdg_pkg::MAX_WIDTH) ? sdg_pkg::MAX_WIDTH : width;
        h = 2 * w_eff;
        for (int i = 0; i < count; i++) begin
            if (h > 0 && $urandom_range(0, 99) < 85) begin
                push_req($urandom_range(0, sdg_pkg::LAST_DIGIT), $urandom_range(0, h - 1));
            end else begin
                push_req($urandom_range(0, 15), $urandom_range(0, 127));
            end
        end
        wait_drained();
    endtask

    always @(negedge i_clk) begin : driver
        t_glyph_req next_req;
        if (!i_valid || in_fire) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_items.pop_front();
                i_valid <= 1'b1;
                i_digit <= next_req.digit;
                i_row_index <= next_req.row;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_row_result want;
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            width_reg <= sdg_pkg::CFG_BITS'(sdg_pkg::RESET_WIDTH);
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("result with no item pending", o_row_pixels, '0);
                end else begin
                    want = expected_rows.pop_front();
                    if (o_row_pixels !== want.pixels) begin
                        report_mismatch("row_pixels", o_row_pixels, want.pixels);
                    end
                    if (o_error_flag !== want.err) begin
                        report_mismatch("error_flag", sdg_pkg::t_pix'(o_error_flag),
                                        sdg_pkg::t_pix'(want.err));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_rows.push_back(glyph_row_of(width_reg, i_digit, i_row_index));
                accepted_count <= accepted_count + 1;
            end
            if (i_cfg_we) begin
                width_reg <= i_cfg_wdata;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 70;
        push_req(0, 0);
        push_req(0, 2);
        push_req(1, 31);
        push_req(2, 10);
        push_req(3, 20);
        push_req(4, 14);
        push_req(4, 15);
        push_req(4, 17);
        push_req(5, 5);
        push_req(6, 25);
        push_req(7, 1);
        push_req(7, 2);
        push_req(8, 14);
        push_req(8, 15);
        push_req(8, 17);
        push_req(9, 30);
        push_req(10, 0);
        push_req(15, 5);
        push_req(0, 32);
        push_req(9, 127);
        push_req(15, 127);
        wait_drained();

        run_phase(8, 100);
        run_phase(64, 100);
        run_phase(0, 20);
        run_phase(15, 100);
        run_phase(17, 100);
        run_phase(24, 100);

        send_idle_pct = 70;
        recv_idle_pct = 31;
        run_phase(7, 20);
        run_phase(65, 100);
        run_phase(127, 100);
        run_phase(33, 100);
        run_phase(40, 100);
        run_phase(47, 100);
        run_phase(9, 100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        run_phase(56, 100);
        run_phase(1, 20);
        run_phase(16, 100);
        run_phase(23, 100);
        run_phase(31, 100);
        run_phase(48, 100);
        run_phase(63, 100);
        run_phase($urandom_range(8, 64), 100);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
